// File: rtl/dqo_pkg.sv
`default_nettype none

package dqo_pkg;

   // Field widths of the result word.
   localparam int SPEED_W   = 16;
   localparam int PULSE_W   = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_ADDR_W = 2;

   // Sum or difference of two wheel speeds, and the divider that takes it.
   localparam int DIV_NUM_W = SPEED_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // Packed stream payload widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 6 * SPEED_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_DIST_PER_PULSE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLES_PER_SEC = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINEAR_DIV      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGULAR_DIV     = 2'd3;

   // Register values after reset.
   localparam logic [CSR_W-1:0] RST_DIST_PER_PULSE = 16'd394;
   localparam logic [CSR_W-1:0] RST_SAMPLES_PER_SEC = 16'd500;
   localparam logic [CSR_W-1:0] RST_LINEAR_DIV      = 16'd200;
   localparam logic [CSR_W-1:0] RST_ANGULAR_DIV     = 16'd240;

   // Saturation bounds of every speed.
   localparam int SPEED_MAX = 32767;
   localparam int SPEED_MIN = -32768;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // a word is taken on the request side
      logic sample;     // the accepted word samples the encoder channels
      logic mult;       // multiply pulse deltas by distance per pulse
      logic scale;      // divide by 256 and clamp the distances
      logic speed;      // scale to mm/s and update the wheel speeds
      logic div_start;  // launch both robot speed divisions
      logic div_store;  // keep the division results
      logic load_out;   // load the response register
   } dqo_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic out_free;
   } dqo_status_type;

endpackage

`default_nettype wire

// File: rtl/dqo_divider.sv
`default_nettype none

module dqo_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [dqo_pkg::DIV_NUM_W-1:0] num,
   input  wire logic        [dqo_pkg::CSR_W-1:0]     den,
   output logic                                     busy,
   output logic signed      [dqo_pkg::SPEED_W-1:0]   quotient
);
   import dqo_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [CSR_W-1:0]      den_ff, den_in;
   logic [DIV_NUM_W-1:0]  rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]  quo_ff, quo_in;

   logic [DIV_NUM_W-1:0]  mag;
   logic [DIV_NUM_W-1:0]  trial;
   logic                  fits;

   // Magnitude of the signed dividend; the most negative value maps to its
   // unsigned pattern, which is the right magnitude.
   assign mag   = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff[DIV_NUM_W-2:0], quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         neg_in  = num[DIV_NUM_W-1];
         zero_in = (den == '0);
         den_in  = den;
         rem_in  = '0;
         quo_in  = mag;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_NUM_W'(trial - {1'b0, den_ff}) : trial;
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // Apply the sign, saturate, and give zero for a zero divisor.
   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (!neg_ff) begin
         if (quo_ff > DIV_NUM_W'(SPEED_MAX)) begin
            quotient = SPEED_W'(SPEED_MAX);
         end else begin
            quotient = SPEED_W'(quo_ff);
         end
      end else begin
         if (quo_ff > DIV_NUM_W'(SPEED_MAX + 1)) begin
            quotient = SPEED_W'(SPEED_MIN);
         end else begin
            quotient = SPEED_W'(-quo_ff);
         end
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// File: rtl/dqo_datapath.sv
`default_nettype none

module dqo_datapath #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [dqo_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [dqo_pkg::CSR_W-1:0]           csr_wdata,
   input  wire logic [dqo_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                               req_tuser,
   input  wire dqo_pkg::dqo_cmd_type               cmd,
   output dqo_pkg::dqo_status_type                 status,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [dqo_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                    rsp_tuser
);
   import dqo_pkg::*;

   localparam int PROD_W = COUNT_BITS + CSR_W + 1;
   localparam int DIST_W = PROD_W - 8;
   localparam int SPP_W  = SPEED_W + CSR_W + 1;

   localparam logic signed [DIST_W-1:0] DIST_HI = DIST_W'(SPEED_MAX);
   localparam logic signed [DIST_W-1:0] DIST_LO = DIST_W'(SPEED_MIN);
   localparam logic signed [SPP_W-1:0]  SPP_HI  = SPP_W'(SPEED_MAX);
   localparam logic signed [SPP_W-1:0]  SPP_LO  = SPP_W'(SPEED_MIN);

   // Configuration registers.
   logic [CSR_W-1:0] dpp_ff, sps_ff, lin_div_ff, ang_div_ff;

   // Encoder state.
   logic                  l_prev_ff, r_prev_ff;
   logic [COUNT_BITS-1:0] l_count_ff, r_count_ff, l_count_in, r_count_in;
   logic [COUNT_BITS-1:0] l_last_ff, r_last_ff;

   // Speed pipeline.
   logic signed [PROD_W-1:0]  l_prod_ff, r_prod_ff, l_prod_in, r_prod_in;
   logic signed [SPEED_W-1:0] l_dist_ff, r_dist_ff, l_dist_in, r_dist_in;
   logic                      l_nz_ff, r_nz_ff, l_nz_in, r_nz_in;
   logic signed [SPEED_W-1:0] l_spd_in, r_spd_in;

   // Held speeds.
   logic signed [SPEED_W-1:0] l_speed_ff, r_speed_ff, lin_speed_ff, ang_speed_ff;
   logic                      fresh_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   // Divider connections.
   logic signed [DIV_NUM_W-1:0] lin_num, ang_num;
   logic signed [SPEED_W-1:0]   lin_quo, ang_quo;
   logic                        lin_busy, ang_busy;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dpp_ff     <= RST_DIST_PER_PULSE;
         sps_ff     <= RST_SAMPLES_PER_SEC;
         lin_div_ff <= RST_LINEAR_DIV;
         ang_div_ff <= RST_ANGULAR_DIV;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DIST_PER_PULSE:  dpp_ff     <= csr_wdata;
            CSR_SAMPLES_PER_SEC: sps_ff     <= csr_wdata;
            CSR_LINEAR_DIV:      lin_div_ff <= csr_wdata;
            CSR_ANGULAR_DIV:     ang_div_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Quadrature decode on a change of channel A. The left wheel counts down
   // when B differs from A; the right wheel has the opposite sense.
   always_comb begin
      l_count_in = l_count_ff;
      r_count_in = r_count_ff;
      if (req_tdata[0] != l_prev_ff) begin
         if (req_tdata[1] != req_tdata[0]) begin
            l_count_in = l_count_ff - 1'b1;
         end else begin
            l_count_in = l_count_ff + 1'b1;
         end
      end
      if (req_tdata[2] != r_prev_ff) begin
         if (req_tdata[3] == req_tdata[2]) begin
            r_count_in = r_count_ff - 1'b1;
         end else begin
            r_count_in = r_count_ff + 1'b1;
         end
      end
   end

   // Signed pulse delta times the Q8 distance per pulse.
   always_comb begin
      l_prod_in = $signed(l_count_ff - l_last_ff) * $signed({1'b0, dpp_ff});
      r_prod_in = $signed(r_count_ff - r_last_ff) * $signed({1'b0, dpp_ff});
   end

   // Divide by 256 toward zero, note a zero distance, and clamp to the speed
   // range; a clamped distance saturates after any nonzero rate as well.
   function automatic logic signed [DIST_W-1:0] div256(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] adj;
      adj = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      return $signed(adj[PROD_W-1:8]);
   endfunction

   function automatic logic signed [SPEED_W-1:0] clamp_dist(input logic signed [DIST_W-1:0] d);
      logic signed [SPEED_W-1:0] r;
      if (d > DIST_HI) begin
         r = SPEED_W'(SPEED_MAX);
      end else if (d < DIST_LO) begin
         r = SPEED_W'(SPEED_MIN);
      end else begin
         r = SPEED_W'(d);
      end
      return r;
   endfunction

   function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SPP_W-1:0] v);
      logic signed [SPEED_W-1:0] r;
      if (v > SPP_HI) begin
         r = SPEED_W'(SPEED_MAX);
      end else if (v < SPP_LO) begin
         r = SPEED_W'(SPEED_MIN);
      end else begin
         r = SPEED_W'(v);
      end
      return r;
   endfunction

   always_comb begin
      l_dist_in = clamp_dist(div256(l_prod_ff));
      r_dist_in = clamp_dist(div256(r_prod_ff));
      l_nz_in   = (div256(l_prod_ff) != '0);
      r_nz_in   = (div256(r_prod_ff) != '0);
      l_spd_in  = sat_speed(SPP_W'(l_dist_ff) * SPP_W'($signed({1'b0, sps_ff})));
      r_spd_in  = sat_speed(SPP_W'(r_dist_ff) * SPP_W'($signed({1'b0, sps_ff})));
   end

   // Robot speed numerators from the wheel speeds just stored.
   assign lin_num = DIV_NUM_W'(r_speed_ff) + DIV_NUM_W'(l_speed_ff);
   assign ang_num = DIV_NUM_W'(r_speed_ff) - DIV_NUM_W'(l_speed_ff);

   dqo_divider u_lin_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (lin_num),
      .den      (lin_div_ff),
      .busy     (lin_busy),
      .quotient (lin_quo)
   );

   dqo_divider u_ang_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (ang_num),
      .den      (ang_div_ff),
      .busy     (ang_busy),
      .quotient (ang_quo)
   );

   // Block state: counts, reference counts and held speeds.
   always_ff @(posedge clock) begin
      if (reset) begin
         l_prev_ff    <= 1'b0;
         r_prev_ff    <= 1'b0;
         l_count_ff   <= '0;
         r_count_ff   <= '0;
         l_last_ff    <= '0;
         r_last_ff    <= '0;
         l_speed_ff   <= '0;
         r_speed_ff   <= '0;
         lin_speed_ff <= '0;
         ang_speed_ff <= '0;
         fresh_ff     <= 1'b0;
      end else begin
         if (cmd.accept) begin
            fresh_ff <= req_tuser;
         end
         if (cmd.sample) begin
            l_prev_ff  <= req_tdata[0];
            r_prev_ff  <= req_tdata[2];
            l_count_ff <= l_count_in;
            r_count_ff <= r_count_in;
         end
         if (cmd.speed) begin
            l_speed_ff <= l_nz_ff ? l_spd_in : '0;
            r_speed_ff <= r_nz_ff ? r_spd_in : '0;
            if (l_nz_ff) begin
               l_last_ff <= l_count_ff;
            end
            if (r_nz_ff) begin
               r_last_ff <= r_count_ff;
            end
         end
         if (cmd.div_store) begin
            lin_speed_ff <= lin_quo;
            ang_speed_ff <= ang_quo;
         end
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         l_prod_ff <= l_prod_in;
         r_prod_ff <= r_prod_in;
      end
      if (cmd.scale) begin
         l_dist_ff <= l_dist_in;
         r_dist_ff <= r_dist_in;
         l_nz_ff   <= l_nz_in;
         r_nz_ff   <= r_nz_in;
      end
   end

   // Response register: holds one word until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {ang_speed_ff, lin_speed_ff, r_speed_ff, l_speed_ff,
                         PULSE_W'(r_count_ff), PULSE_W'(l_count_ff)};
         rsp_user_ff <= fresh_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;
   assign status.div_busy = lin_busy || ang_busy;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

// File: rtl/dqo_ctrl.sv
`default_nettype none

module dqo_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_op,
   output logic                         req_tready,
   input  wire dqo_pkg::dqo_status_type status,
   output dqo_pkg::dqo_cmd_type         cmd
);
   import dqo_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DIST     = 7'b0000010,
      S_SCALE    = 7'b0000100,
      S_SPEED    = 7'b0001000,
      S_DIV_GO   = 7'b0010000,
      S_DIV_WAIT = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = accept;
      cmd.sample    = accept && !req_op;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_op ? S_DIST : S_DONE;
            end
         end
         S_DIST: begin
            cmd.mult = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_SPEED;
         end
         S_SPEED: begin
            cmd.speed = 1'b1;
            state_in  = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!status.div_busy) begin
               cmd.div_store = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/dual_quadrature_odometry.sv
// Encoder sample word: after acceptance its response word is loaded from S_DONE
// once the response register is free; no word is accepted until then.
// Velocity word: its response word is loaded after a three-stage speed pipeline
// and the two 17-step serial dividers that run in parallel, once the response
// register is free; the request side stays closed until that load.
// The response register lets the next word be accepted while a result waits.
// Synchronous active-high reset clears counts, speeds and the response valid,
// and loads the configuration registers with their defaults.
`default_nettype none

module dual_quadrature_odometry #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Configuration write port.
   input  wire logic                          csr_we,
   input  wire logic [dqo_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [dqo_pkg::CSR_W-1:0]      csr_wdata,
   // Request stream.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [0] left_chan_a, [1] left_chan_b, [2] right_chan_a, [3] right_chan_b,
   // [7:4] zero
   input  wire logic [dqo_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                          req_tuser,
   // Response stream.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] left_pulses, [31:16] right_pulses, [47:32] left_speed,
   // [63:48] right_speed, [79:64] linear_speed, [95:80] angular_speed
   output logic      [dqo_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] speeds_fresh
   output logic                               rsp_tuser
);
   import dqo_pkg::*;

   dqo_cmd_type    cmd;
   dqo_status_type status;

   dqo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dqo_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/dqo_checker.sv
`default_nettype none

module dqo_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          csr_we,
   input wire logic [dqo_pkg::CSR_ADDR_W-1:0] csr_addr,
   input wire logic [dqo_pkg::CSR_W-1:0]      csr_wdata,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [dqo_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                          req_tuser,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [dqo_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                          rsp_tuser
);

   // A pending response word is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response valid dropped before the word was taken");

   // A sample word accepted with the response side empty is answered from S_DONE with no wait.
   a_sample_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |-> ##2 rsp_tvalid)
      else $error("sample word not answered on time");

   // A velocity word keeps the request side closed while it is computed.
   a_velocity_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("request accepted during a velocity computation");

   // Reset leaves no response word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind dual_quadrature_odometry dqo_checker u_dqo_checker (.*);

`default_nettype wire
